>>> hw/rtl/assert_macros.svh
// assertion macros shared by the greyscale converter modules
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition in the same cycle
`define P2G_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("p2g assertion failed");

// condition in the following cycle
`define P2G_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("p2g assertion failed");

`endif

>>> hw/rtl/p2g_pkg.sv
// package for the pixel to greyscale converter: formats, item kinds, weights
// and the queue item type; no dependencies
package p2g_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int MAP_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] FMT_INDEXED = 2'd0;
    localparam logic [1:0] FMT_RGB565 = 2'd1;
    localparam logic [1:0] FMT_RGB24 = 2'd2;
    localparam logic [1:0] FMT_RGB32 = 2'd3;
    localparam logic [1:0] FMT_RESET = FMT_RGB24;

    localparam logic [1:0] KIND_PALETTE = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_DIRECT = 2'd2;

    localparam logic [15:0] WEIGHT_RED = 16'd19595;
    localparam logic [15:0] WEIGHT_GREEN = 16'd38469;
    localparam logic [15:0] WEIGHT_BLUE = 16'd7471;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] index;
        logic       in_range;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } item_t;

endpackage

>>> hw/rtl/p2g_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module p2g_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/p2g_front.sv
// front end: classifies an incoming transaction by kind and source format
// and unpacks the colour channels; uses p2g_pkg
module p2g_front (
    input  logic             mode,
    input  logic [31:0]      pixel,
    input  logic [7:0]       palette_index,
    input  logic [7:0]       red,
    input  logic [7:0]       green,
    input  logic [7:0]       blue,
    input  logic [1:0]       source_format,
    output p2g_pkg::item_t   item
);

    always_comb
    begin
        item.kind = p2g_pkg::KIND_DIRECT;
        item.index = pixel[7:0];
        item.in_range = ({1'b0, pixel[7:0]} < 9'(p2g_pkg::PALETTE_ENTRIES));
        item.red = pixel[23:16];
        item.green = pixel[15:8];
        item.blue = pixel[7:0];
        if (mode)
        begin
            item.kind = p2g_pkg::KIND_PALETTE;
            item.index = palette_index;
            item.in_range = ({1'b0, palette_index} < 9'(p2g_pkg::PALETTE_ENTRIES));
            item.red = red;
            item.green = green;
            item.blue = blue;
        end
        else
        begin
            unique case (source_format) inside
                p2g_pkg::FMT_INDEXED:
                begin
                    item.kind = p2g_pkg::KIND_LOOKUP;
                end
                p2g_pkg::FMT_RGB565:
                begin
                    item.red = {pixel[15:11], 3'b000};
                    item.green = {pixel[10:5], 2'b00};
                    item.blue = {pixel[4:0], 3'b000};
                end
                p2g_pkg::FMT_RGB24, p2g_pkg::FMT_RGB32:
                begin
                    item.kind = p2g_pkg::KIND_DIRECT;
                end
                default:
                begin
                    item.kind = p2g_pkg::KIND_DIRECT;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/p2g_queue.sv
// short queue between front and back end
// uses p2g_pkg and assert_macros.svh
`include "assert_macros.svh"

module p2g_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  p2g_pkg::item_t push_item,
    input  logic           pop,
    output logic           full,
    output logic           empty,
    output p2g_pkg::item_t head
);

    p2g_pkg::item_t                  slot_reg [p2g_pkg::QUEUE_DEPTH];
    logic [p2g_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [p2g_pkg::QUEUE_AW-1:0]    wr_ptr_next;
    logic [p2g_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [p2g_pkg::QUEUE_AW-1:0]    rd_ptr_next;
    logic [p2g_pkg::QUEUE_CW-1:0]    count_reg;
    logic [p2g_pkg::QUEUE_CW-1:0]    count_next;

    assign full = (count_reg == p2g_pkg::QUEUE_CW'(p2g_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    `P2G_ASSERT_SAME(a_no_pop_empty, clk, rst_n, pop, !empty)
    `P2G_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= p2g_pkg::QUEUE_CW'(p2g_pkg::QUEUE_DEPTH))

endmodule

>>> hw/rtl/p2g_back.sv
// back end: weight multiplies, grey map write and lookup, output register
// uses p2g_pkg, p2g_ram and assert_macros.svh
`include "assert_macros.svh"

module p2g_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  p2g_pkg::item_t head,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     grey
);

    logic                              adv;
    logic                              b_valid_reg;
    logic [1:0]                        b_kind_reg;
    logic [p2g_pkg::MAP_AW-1:0]        b_addr_reg;
    logic                              b_in_range_reg;
    logic [23:0]                       b_prod_r_reg;
    logic [23:0]                       b_prod_g_reg;
    logic [23:0]                       b_prod_b_reg;
    logic                              b_map_valid_reg;
    logic                              b_hit_reg;
    logic [7:0]                        b_byp_reg;
    logic [p2g_pkg::PALETTE_ENTRIES-1:0] map_valid_reg;
    logic [p2g_pkg::MAP_AW-1:0]        head_addr;
    logic                              hit;
    logic                              map_we;
    logic [7:0]                        map_q;
    logic [25:0]                       palette_sum;
    logic [9:0]                        direct_sum;
    logic [7:0]                        b_grey;
    logic                              out_valid_reg;
    logic [7:0]                        grey_reg;

    assign adv = !out_valid_reg || !out_stall;
    assign pop = adv && !empty;
    assign head_addr = head.index[p2g_pkg::MAP_AW-1:0];

    // write in flight to the address being read
    assign hit = b_valid_reg && (b_kind_reg == p2g_pkg::KIND_PALETTE) && b_in_range_reg
        && (b_addr_reg == head_addr);

    assign palette_sum = 26'(b_prod_r_reg) + 26'(b_prod_g_reg) + 26'(b_prod_b_reg);
    assign direct_sum = 10'(b_prod_r_reg[23:16]) + 10'(b_prod_g_reg[23:16])
        + 10'(b_prod_b_reg[23:16]);

    always_comb
    begin
        unique case (b_kind_reg)
            p2g_pkg::KIND_PALETTE:
            begin
                b_grey = palette_sum[23:16];
            end
            p2g_pkg::KIND_LOOKUP:
            begin
                if (!b_in_range_reg)
                begin
                    b_grey = '0;
                end
                else if (b_hit_reg)
                begin
                    b_grey = b_byp_reg;
                end
                else if (b_map_valid_reg)
                begin
                    b_grey = map_q;
                end
                else
                begin
                    b_grey = '0;
                end
            end
            default:
            begin
                b_grey = direct_sum[7:0];
            end
        endcase
    end

    assign map_we = adv && b_valid_reg && (b_kind_reg == p2g_pkg::KIND_PALETTE)
        && b_in_range_reg;

    p2g_ram #(
        .WIDTH(8),
        .DEPTH(p2g_pkg::PALETTE_ENTRIES)
    ) u_grey_map (
        .clk  (clk),
        .we   (map_we),
        .waddr(b_addr_reg),
        .wdata(b_grey),
        .re   (pop),
        .raddr(head_addr),
        .rdata(map_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            map_valid_reg <= '0;
        end
        else
        begin
            if (adv)
            begin
                b_valid_reg <= !empty;
                out_valid_reg <= b_valid_reg && (b_kind_reg != p2g_pkg::KIND_PALETTE);
            end
            if (map_we)
            begin
                map_valid_reg[b_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_kind_reg <= head.kind;
            b_addr_reg <= head_addr;
            b_in_range_reg <= head.in_range;
            b_prod_r_reg <= 24'(head.red) * 24'(p2g_pkg::WEIGHT_RED);
            b_prod_g_reg <= 24'(head.green) * 24'(p2g_pkg::WEIGHT_GREEN);
            b_prod_b_reg <= 24'(head.blue) * 24'(p2g_pkg::WEIGHT_BLUE);
            b_map_valid_reg <= map_valid_reg[head_addr];
            b_hit_reg <= hit;
            b_byp_reg <= b_grey;
        end
        if (adv)
        begin
            grey_reg <= b_grey;
        end
    end

    assign out_valid = out_valid_reg;
    assign grey = grey_reg;

    `P2G_ASSERT_NEXT(a_palette_no_result, clk, rst_n,
        adv && b_valid_reg && (b_kind_reg == p2g_pkg::KIND_PALETTE), !out_valid_reg)
    `P2G_ASSERT_NEXT(a_pixel_result, clk, rst_n,
        adv && b_valid_reg && (b_kind_reg != p2g_pkg::KIND_PALETTE), out_valid_reg)

endmodule

>>> hw/rtl/pixel_to_greyscale_unit.sv
// pixel to greyscale converter, top level; uses p2g_pkg, p2g_front, p2g_queue, p2g_back
// a pixel transaction passes through the queue slot, the back-end stage registers and the output register
// throughput: one transaction per cycle while the output is not stalled, set by the queue pop and map read
// reset: source format returns to 24-bit rgb, grey map valid bits clear at once
// (no clearing pass), queue and output empty
module pixel_to_greyscale_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [31:0] pixel,
    input  logic [7:0]  palette_index,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  grey,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);

    logic [1:0]     source_format_reg;
    p2g_pkg::item_t front_item;
    p2g_pkg::item_t head;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    logic           q_push;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_format_reg <= p2g_pkg::FMT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            source_format_reg <= cfg_data;
        end
    end

    assign in_stall = q_full;
    assign q_push = in_valid && !q_full;

    p2g_front u_front (
        .mode         (mode),
        .pixel        (pixel),
        .palette_index(palette_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .source_format(source_format_reg),
        .item         (front_item)
    );

    p2g_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_item(front_item),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    p2g_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (q_empty),
        .head     (head),
        .pop      (q_pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .grey     (grey)
    );

endmodule

>>> verif/pixel_to_greyscale_unit_tb.sv
// testbench for pixel_to_greyscale_unit: directed and random pixel and palette traffic
// with grey values predicted in the bench and checked in order; uses p2g_pkg
`timescale 1ns / 1ps

module pixel_to_greyscale_unit_tb;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_PALETTE = 1'b1;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_PHASES = 15;
    localparam int PHASE_ITEMS = 105;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        mode = MODE_PIXEL;
    logic [31:0] pixel = '0;
    logic [7:0]  palette_index = '0;
    logic [7:0]  red = '0;
    logic [7:0]  green = '0;
    logic [7:0]  blue = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  grey;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data = '0;

    logic [1:0]  active_format = p2g_pkg::FMT_RESET;
    logic [7:0]  grey_map [0:255];
    logic [7:0]  mapped_indices [$];
    logic [7:0]  pending_greys [$];
    logic        quiet = 1'b0;
    logic        hold_off = 1'b0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    int          mismatch_count = 0;
    int          pixel_count = 0;
    int          palette_count = 0;
    int          greys_checked = 0;
    int          config_count = 0;

    pixel_to_greyscale_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .pixel         (pixel),
        .palette_index (palette_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .grey          (grey),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_wait();
        if (quiet)
        begin
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [7:0] weighted_channel(input logic [7:0] value,
                                                    input logic [15:0] weight);
        logic [31:0] product;
        product = value * weight;
        return product[23:16];
    endfunction

    function automatic logic [7:0] expected_grey(input logic [31:0] px);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        case (active_format)
            p2g_pkg::FMT_INDEXED:
            begin
                return (px[7:0] < p2g_pkg::PALETTE_ENTRIES) ? grey_map[px[7:0]] : 8'd0;
            end
            p2g_pkg::FMT_RGB565:
            begin
                r = {px[15:11], 3'b000};
                g = {px[10:5], 2'b00};
                b = {px[4:0], 3'b000};
            end
            default:
            begin
                r = px[23:16];
                g = px[15:8];
                b = px[7:0];
            end
        endcase
        return weighted_channel(r, p2g_pkg::WEIGHT_RED)
               + weighted_channel(g, p2g_pkg::WEIGHT_GREEN)
               + weighted_channel(b, p2g_pkg::WEIGHT_BLUE);
    endfunction

    task automatic store_palette_grey(input logic [7:0] idx, input logic [7:0] r,
                                      input logic [7:0] g, input logic [7:0] b);
        logic [31:0] weighted_sum;
        weighted_sum = r * p2g_pkg::WEIGHT_RED + g * p2g_pkg::WEIGHT_GREEN
                       + b * p2g_pkg::WEIGHT_BLUE;
        if (idx < p2g_pkg::PALETTE_ENTRIES)
        begin
            grey_map[idx] = weighted_sum[23:16];
            mapped_indices.push_back(idx);
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // one input transaction; valid stays high when no gap follows
    task automatic offer_item(input logic m, input logic [31:0] px, input logic [7:0] idx,
                              input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        int gap;
        in_valid <= 1'b1;
        mode <= m;
        pixel <= px;
        palette_index <= idx;
        red <= r;
        green <= g;
        blue <= b;
        do
            @(posedge clk);
        while (in_stall);
        if (m == MODE_PALETTE)
        begin
            store_palette_grey(idx, r, g, b);
            palette_count++;
        end
        else
        begin
            pending_greys.push_back(expected_grey(px));
            pixel_count++;
        end
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic offer_pixel(input logic [31:0] px);
        offer_item(MODE_PIXEL, px, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom));
    endtask

    task automatic offer_palette(input logic [7:0] idx, input logic [7:0] r,
                                 input logic [7:0] g, input logic [7:0] b);
        offer_item(MODE_PALETTE, $urandom, idx, r, g, b);
    endtask

    task automatic stop_input();
        in_valid <= 1'b0;
    endtask

    task automatic write_format(input logic [1:0] fmt);
        stop_input();
        while (pending_greys.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= fmt;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        active_format = fmt;
        config_count++;
    endtask

    task automatic test_reset_format();
        offer_pixel(32'h0000_0000);
        offer_pixel(32'hFFFF_FFFF);
        offer_pixel(32'h00FF_0000);
        offer_pixel(32'hAA00_FF00);
        offer_pixel(32'h5500_00FF);
    endtask

    task automatic test_palette_lookup();
        // palette entries are taken outside indexed mode too
        offer_palette(8'd0, 8'd255, 8'd255, 8'd255);
        offer_palette(8'd255, 8'd255, 8'd0, 8'd0);
        offer_palette(8'd128, 8'd0, 8'd255, 8'd0);
        offer_palette(8'd1, 8'd0, 8'd0, 8'd255);
        write_format(p2g_pkg::FMT_INDEXED);
        offer_pixel(32'hFFFF_FF00);
        offer_pixel(32'h0000_00FF);
        offer_pixel(32'h1234_5680);
        offer_pixel(32'h0000_0001);
        // entry never written reads zero
        offer_pixel(32'hDEAD_BE4D);
        offer_palette(8'd0, 8'd0, 8'd0, 8'd0);
        offer_pixel(32'hFFFF_FF00);
    endtask

    task automatic test_rgb565_extremes();
        write_format(p2g_pkg::FMT_RGB565);
        offer_pixel(32'h0000_0000);
        offer_pixel(32'hFFFF_FFFF);
        offer_pixel(32'h0000_F800);
        offer_pixel(32'h0000_07E0);
        offer_pixel(32'hABCD_001F);
    endtask

    task automatic test_rgb32_extremes();
        write_format(p2g_pkg::FMT_RGB32);
        offer_pixel(32'hFFFF_FFFF);
        offer_pixel(32'h0100_0000);
        offer_pixel(32'h00FF_FFFF);
    endtask

    task automatic test_backpressure();
        write_format(p2g_pkg::FMT_RGB24);
        quiet <= 1'b1;
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        repeat (60) offer_pixel($urandom);
        quiet <= 1'b0;
    endtask

    task automatic test_random_traffic();
        logic [1:0]  fmt;
        logic [31:0] px;
        bit          palette_item;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            fmt = (phase < 4) ? phase[1:0] : 2'($urandom_range(0, 3));
            write_format(fmt);
            quiet <= ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS)
            begin
                palette_item = ($urandom_range(0, 3) == 0)
                               || (fmt == p2g_pkg::FMT_INDEXED && $urandom_range(0, 2) == 0);
                if (palette_item)
                begin
                    offer_palette(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                end
                else
                begin
                    px = $urandom;
                    if (fmt == p2g_pkg::FMT_INDEXED && mapped_indices.size() != 0
                        && $urandom_range(0, 3) != 0)
                    begin
                        px[7:0] = mapped_indices[$urandom_range(0, mapped_indices.size() - 1)];
                    end
                    offer_pixel(px);
                end
            end
        end
        quiet <= 1'b0;
    endtask

    // receiver: stalls for a wait drawn by draw_wait after each transaction, and throughout hold_off
    always @(posedge clk)
    begin
        if (hold_off)
        begin
            out_stall <= 1'b1;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                stall_left = draw_wait();
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_greys.size() == 0)
            begin
                report_mismatch($sformatf("unexpected grey %0d", grey));
            end
            else
            begin
                if (grey !== pending_greys[0])
                begin
                    report_mismatch($sformatf("grey %0d, expected %0d",
                                              grey, pending_greys[0]));
                end
                void'(pending_greys.pop_front());
                greys_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("no progress for %0d cycles", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < 256; i++)
        begin
            grey_map[i] = 8'd0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_format();
        test_palette_lookup();
        test_rgb565_extremes();
        test_rgb32_extremes();
        test_backpressure();
        test_random_traffic();
        stop_input();
        while (pending_greys.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        $display("covered %0d pixel and %0d palette transactions over %0d format writes",
                 pixel_count, palette_count, config_count);
        $display("compared %0d grey values, %0d mismatches", greys_checked, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
